/* hw/rtl/mppd_pkg.sv */
// shared constants for the mean pairwise point distance block
// no dependencies
package mppd_pkg;
	localparam int CoordW = 16;
	localparam int AvgW   = 25;
	localparam int CountW = 9;
	localparam int D2W    = 34;   // dx^2+dy^2, dx,dy 17 bits signed
	localparam int RootW  = 25;   // floor(sqrt(d2*65536))
	localparam int SumW   = 64;
endpackage

/* hw/rtl/mean_pairwise_point_distance.sv */
// top level: mean pairwise euclidean distance of a set of 2-D points
// depends on mppd_pkg, mppd_ram, mppd_isqrt, mppd_div
//
// usage
// - input channel (in_valid/in_ready) takes one point per transaction;
//   last_point closes the set. points past MAX_POINTS are dropped and
//   flag overflow.
// - output channel (out_valid/out_ready) gives one transaction per set:
//   avg_distance (q8, truncated), point_count, overflow.
// - a non-last point is stored and the block stays ready for the next point.
// - a last point starts a sweep over all N*N ordered pairs held in two
//   coordinate rams (x, y). each pair costs a row read, a column read,
//   a squared distance and a serial square root; the serial root unit
//   sets the pace.
// - the final mean comes from a serial divider that divides the sum of
//   the roots by N*N.
// - the result sits in an output register; the next set's points are
//   not taken until it is delivered, so a stalled receiver holds the
//   block.
// - reset clears the count and the overflow flag; ram contents are left.
module mean_pairwise_point_distance #(
	parameter int MAX_POINTS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [15:0]           point_x,
	input  logic signed [15:0]           point_y,
	input  logic                         last_point,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mppd_pkg::AvgW-1:0]    avg_distance,
	output logic [mppd_pkg::CountW-1:0]  point_count,
	output logic                         overflow
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int SW = mppd_pkg::SumW;
	localparam int DW = 2 * NW;
	localparam int CW = mppd_pkg::CoordW;

	typedef enum logic [2:0] {
		ST_FILL, ST_READ, ST_WAIT, ST_SQ, ST_ROOT, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;
	logic [NW-1:0] count_q;
	logic          drop_q;
	logic [AW-1:0] i_q, j_q;
	logic          phase_q;       // 0: read row i, 1: read column j
	logic [SW-1:0] sum_q;
	logic signed [CW-1:0] xi_q, yi_q;
	logic [mppd_pkg::D2W-1:0] d2;
	logic          root_start, div_start;
	logic          root_done, div_done;
	logic [mppd_pkg::RootW-1:0] root;
	logic [SW-1:0] quo;
	logic          wr;
	logic [AW-1:0] raddr;
	logic signed [CW-1:0] xr, yr;
	logic signed [CW:0]   dx, dy;
	logic [NW-1:0] last_idx;

	assign in_ready = (state_q == ST_FILL);
	assign wr       = in_valid && in_ready && (count_q < NW'(MAX_POINTS));
	assign raddr    = phase_q ? j_q : i_q;
	assign last_idx = count_q - 1'b1;

	mppd_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_xram (
		.clk(clk), .we(wr), .waddr(count_q[AW-1:0]), .wdata(point_x),
		.raddr(raddr), .rdata(xr)
	);
	mppd_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_yram (
		.clk(clk), .we(wr), .waddr(count_q[AW-1:0]), .wdata(point_y),
		.raddr(raddr), .rdata(yr)
	);

	// row point held in xi/yi, column point straight from the rams
	assign dx = (CW+1)'(xi_q) - (CW+1)'(xr);
	assign dy = (CW+1)'(yi_q) - (CW+1)'(yr);
	assign d2 = mppd_pkg::D2W'(dx * dx) + mppd_pkg::D2W'(dy * dy);

	mppd_isqrt u_root (
		.clk(clk), .arst_n(arst_n), .start(root_start), .d2(d2),
		.done(root_done), .root(root)
	);
	mppd_div #(.NW(SW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sum_q),
		.den(DW'(count_q) * DW'(count_q)), .done(div_done), .quo(quo)
	);

	// the last pair is a self-pair with a zero root, so the divider can
	// take the sum on the same edge
	assign root_start = (state_q == ST_SQ);
	assign div_start  = (state_q == ST_ROOT) && root_done
		&& (i_q == last_idx[AW-1:0]) && (j_q == last_idx[AW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			count_q   <= '0;
			drop_q    <= 1'b0;
			out_valid <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			phase_q   <= 1'b0;
			sum_q     <= '0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (in_valid) begin
						if (wr)
							count_q <= count_q + 1'b1;
						else
							drop_q <= 1'b1;
						if (last_point) begin
							state_q <= ST_READ;
							i_q     <= '0;
							j_q     <= '0;
							phase_q <= 1'b0;
							sum_q   <= '0;
						end
					end
				end
				// row point read issued; then issue column read
				ST_READ: begin
					phase_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				// row point on the ram outputs; latch it
				ST_WAIT: begin
					xi_q    <= xr;
					yi_q    <= yr;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						sum_q <= sum_q + SW'(root);
						if (div_start) begin
							state_q <= ST_DIV;
						end else begin
							if (j_q == last_idx[AW-1:0]) begin
								j_q     <= '0;
								i_q     <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							phase_q <= 1'b0;
							state_q <= ST_READ;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						avg_distance <= quo[mppd_pkg::AvgW-1:0];
						point_count  <= mppd_pkg::CountW'(count_q);
						overflow     <= drop_q;
						out_valid    <= 1'b1;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						count_q   <= '0;
						drop_q    <= 1'b0;
						state_q   <= ST_FILL;
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end
endmodule

/* hw/rtl/mppd_ram.sv */
// generic single-port-write, single-read synchronous ram, registered read
// no dependencies
module mppd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/mppd_isqrt.sv */
// iterative integer square root, one result bit per cycle
// depends on mppd_pkg
module mppd_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mppd_pkg::D2W-1:0]        d2,
	output logic                            done,
	output logic [mppd_pkg::RootW-1:0]      root
);
	localparam int RW = mppd_pkg::RootW;
	localparam int VW = 2 * RW;
	localparam int IW = $clog2(RW);
	logic [VW-1:0] rem_q;
	logic [VW-1:0] v_q;
	logic [RW-1:0] res_q;
	logic [IW-1:0] cnt_q;
	logic          busy_q;
	logic [VW-1:0] rem_n;
	logic [VW-1:0] trial;

	// restoring method, radicand = d2 << 16, two radicand bits per step
	always_comb begin
		rem_n = {rem_q[VW-3:0], v_q[VW-1:VW-2]};
		trial = {res_q[RW-2:0], 2'b01} > VW'(0) ? VW'({res_q, 2'b01}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= IW'(RW - 1);
				rem_q  <= '0;
				res_q  <= '0;
				v_q    <= VW'({d2, 16'h0000});
			end else if (busy_q) begin
				v_q <= {v_q[VW-3:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q <= rem_n - trial;
					res_q <= {res_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					res_q <= {res_q[RW-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end
	assign root = res_q;
endmodule

/* hw/rtl/mppd_div.sv */
// iterative restoring divider, one quotient bit per cycle
// no dependencies
module mppd_div #(
	parameter int NW = 64,
	parameter int DW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW);
	logic [DW:0]   rem_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   sh;

	assign sh = {rem_q[DW-1:0], q_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rem_q  <= '0;
				q_q    <= num;
				den_q  <= den;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				if (sh >= {1'b0, den_q}) begin
					rem_q <= sh - {1'b0, den_q};
					q_q   <= {q_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= sh;
					q_q   <= {q_q[NW-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end
	assign quo = q_q;
endmodule

/* tb/sv/mppd_checker.sv */
`timescale 1ns / 1ps
// checker for the mean pairwise point distance block: watches both channels,
// predicts each set's mean distance and compares; depends on mppd_pkg
module mppd_checker #(
	parameter int MAX_POINTS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [15:0]           point_x,
	input  logic signed [15:0]           point_y,
	input  logic                         last_point,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [mppd_pkg::AvgW-1:0]    avg_distance,
	input  logic [mppd_pkg::CountW-1:0]  point_count,
	input  logic                         overflow,
	output int                           fail_count,
	output int                           sets_pending
);
	typedef struct packed {
		logic [mppd_pkg::AvgW-1:0]   avg;
		logic [mppd_pkg::CountW-1:0] cnt;
		logic                        ovf;
	} set_result_t;

	logic signed [15:0] held_x [MAX_POINTS];
	logic signed [15:0] held_y [MAX_POINTS];
	int                 held_n;
	logic               held_drop;
	set_result_t        mean_q [$];

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			b = r | (64'd1 << k);
			if (b * b <= v) r = b;
		end
		return r;
	endfunction

	function automatic set_result_t mean_distance();
		longint unsigned acc, d2, nn;
		longint dx, dy;
		set_result_t r;
		acc = 0;
		for (int i = 0; i < held_n; i++)
			for (int j = 0; j < held_n; j++) begin
				dx = longint'(held_x[i]) - longint'(held_x[j]);
				dy = longint'(held_y[i]) - longint'(held_y[j]);
				d2 = dx * dx + dy * dy;
				acc += root_floor(d2 << 16);
			end
		nn = longint'(held_n) * longint'(held_n);
		r.avg = (nn != 0) ? mppd_pkg::AvgW'(acc / nn) : '0;
		r.cnt = mppd_pkg::CountW'(held_n);
		r.ovf = held_drop;
		return r;
	endfunction

	assign sets_pending = mean_q.size();

	always @(posedge clk or negedge arst_n) begin
		set_result_t want;
		if (!arst_n) begin
			held_n     = 0;
			held_drop  = 0;
			fail_count = 0;
			mean_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (held_n < MAX_POINTS) begin
					held_x[held_n] = point_x;
					held_y[held_n] = point_y;
					held_n++;
				end else begin
					held_drop = 1;
				end
				if (last_point) begin
					mean_q    = {mean_q, mean_distance()};
					held_n    = 0;
					held_drop = 0;
				end
			end
			if (out_valid && out_ready) begin
				if (mean_q.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					want = mean_q.pop_front();
					if (avg_distance !== want.avg) begin
						$error("avg_distance expected %0d got %0d", want.avg, avg_distance);
						fail_count++;
					end
					if (point_count !== want.cnt) begin
						$error("point_count expected %0d got %0d", want.cnt, point_count);
						fail_count++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow expected %0d got %0d", want.ovf, overflow);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

/* tb/sv/mean_pairwise_point_distance_tb.sv */
`timescale 1ns / 1ps
// top of the mean pairwise point distance testbench: clock, reset, stimulus
// and verdict; depends on mppd_pkg, mppd_checker and the block itself
module mean_pairwise_point_distance_tb;
	localparam int CAP = 256;

	logic                          clk = 0;
	logic                          arst_n = 0;
	logic                          in_valid = 0;
	logic                          in_ready;
	logic signed [15:0]            point_x = '0;
	logic signed [15:0]            point_y = '0;
	logic                          last_point = 0;
	logic                          out_valid;
	logic                          out_ready = 0;
	logic [mppd_pkg::AvgW-1:0]     avg_distance;
	logic [mppd_pkg::CountW-1:0]   point_count;
	logic                          overflow;
	int                            fail_count;
	int                            sets_pending;

	// idle percentages for the current phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	mean_pairwise_point_distance #(.MAX_POINTS(CAP)) DUT (.*);

	mppd_checker #(.MAX_POINTS(CAP)) u_checker (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: random stalls per phase
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// one point transaction, with random gaps before it
	task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
		input logic lp);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1;
		point_x    <= px;
		point_y    <= py;
		last_point <= lp;
		do @(posedge clk); while (!in_ready);
	endtask

	// a set of n points; mostly full-range coordinates, sometimes a tight cluster
	task automatic send_random_set(input int n);
		logic signed [15:0] cx, cy;
		int spread;
		cx = 16'($urandom);
		cy = 16'($urandom);
		spread = $urandom_range(3) == 0 ? int'($urandom_range(255)) : -1;
		for (int k = 0; k < n; k++) begin
			if (spread < 0)
				send_point(16'($urandom), 16'($urandom), k == n - 1);
			else
				send_point(16'(cx + $signed($urandom_range(2 * spread)) - spread),
					16'(cy + $signed($urandom_range(2 * spread)) - spread), k == n - 1);
		end
	endtask

	initial begin
		#(200_000_000);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int items;
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single point: mean distance zero
		send_point(16'sh7fff, -16'sh8000, 1'b1);
		// opposite corners, the widest distance
		send_point(-16'sh8000, -16'sh8000, 1'b0);
		send_point(16'sh7fff, 16'sh7fff, 1'b1);
		send_point(-16'sh8000, 16'sh7fff, 1'b0);
		send_point(16'sh7fff, -16'sh8000, 1'b1);
		// two coincident points, plus a third point at (-1, -1)
		send_point(16'sh0000, 16'sh0000, 1'b0);
		send_point(16'sh0000, 16'sh0000, 1'b0);
		send_point(16'shffff, 16'shffff, 1'b1);
		// capacity full: one extra point dropped, then a dropped last point
		for (int k = 0; k < CAP + 2; k++)
			send_point(16'($urandom), 16'($urandom), k == CAP + 1);
		in_valid <= 0;

		// random sets through the idling phases
		items = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			while (items < (ph + 1) * 320) begin
				n = ($urandom_range(19) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
				send_random_set(n);
				items += n;
			end
			in_valid <= 0;
		end

		// let the checker record the last set before waiting on it
		@(posedge clk);
		while (sets_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/mppd_pkg.sv
hw/rtl/mppd_ram.sv
hw/rtl/mppd_isqrt.sv
hw/rtl/mppd_div.sv
hw/rtl/mean_pairwise_point_distance.sv
tb/sv/mppd_checker.sv
tb/sv/mean_pairwise_point_distance_tb.sv
